// File: sv/assert_macros.svh
// assertion helpers for the executor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_CLK(lbl, clk, rst, !(cond), msg)

`endif

// File: sv/lc2k_pkg.sv
package lc2k_pkg;

   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 16;
   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = 3;

   // instruction word fields
   localparam int OPC_LSB = 22;
   localparam int RA_LSB  = 19;
   localparam int RB_LSB  = 16;
   localparam int RD_LSB  = 0;
   localparam int OFF_W   = 16;

   typedef enum logic [2:0] {
      OPC_ADD  = 3'd0,
      OPC_NOR  = 3'd1,
      OPC_LW   = 3'd2,
      OPC_SW   = 3'd3,
      OPC_BEQ  = 3'd4,
      OPC_JALR = 3'd5,
      OPC_HALT = 3'd6,
      OPC_NOOP = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      OPER_LOAD  = 2'd0,
      OPER_EXEC  = 2'd1,
      OPER_RDREG = 2'd2,
      OPER_RDMEM = 2'd3
   } oper_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_HALTED     = 2'd1,
      STAT_PC_RANGE   = 2'd2,
      STAT_ADDR_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RESP,
      ST_FETCH,
      ST_EXEC,
      ST_LOAD
   } state_type;

   // single port word memory request
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } word_req_type;

   // register file request: one write, two reads
   typedef struct packed {
      logic                 wr_en;
      logic [REG_IDX_W-1:0] wr_idx;
      logic [DATA_W-1:0]    wr_data;
      logic                 rd_en;
      logic [REG_IDX_W-1:0] rd_idx_a;
      logic [REG_IDX_W-1:0] rd_idx_b;
   } rf_req_type;

endpackage

// File: sv/lc2k_word_mem.sv
module lc2k_word_mem
   import lc2k_pkg::*;
#(
   parameter int Depth = 65536
) (
   input  logic              clock,
   input  word_req_type      req,
   output logic [DATA_W-1:0] rdata
);

   localparam int AddrW = $clog2(Depth);

   logic [DATA_W-1:0] mem_ff [Depth];
   logic [DATA_W-1:0] rdata_ff;

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.addr[AddrW-1:0]] <= req.wdata;
      end
      if (req.rd_en) begin
         rdata_ff <= mem_ff[req.addr[AddrW-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/lc2k_reg_file.sv
module lc2k_reg_file
   import lc2k_pkg::*;
(
   input  logic              clock,
   input  rf_req_type        req,
   output logic [DATA_W-1:0] rdata_a,
   output logic [DATA_W-1:0] rdata_b
);

   logic [DATA_W-1:0] regs_ff [REG_COUNT];
   logic [DATA_W-1:0] rdata_a_ff;
   logic [DATA_W-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         regs_ff[req.wr_idx] <= req.wr_data;
      end
      if (req.rd_en) begin
         rdata_a_ff <= regs_ff[req.rd_idx_a];
         rdata_b_ff <= regs_ff[req.rd_idx_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// File: sv/lc2k_instruction_executor.sv
// Eight-register 32-bit word machine with one word memory shared by program and data.
// Each req transfer loads a memory word, executes one instruction at the program counter,
// reads a register or reads a memory word, and gives exactly one rsp transfer back.
// After reset the block sweeps the word memory and the register file to zero, one word a
// cycle, over all MEM_DEPTH words; req_tready stays low during that pass. Afterwards an
// item is accepted and its result is written to the output register in its last step:
// load and read items go through accept and respond, an execute goes through accept with
// instruction fetch, register read, and execute and write back, lw adds a data read step
// since it needs a second pass through the single word memory port, and an execute while
// halted or with the pc out of range goes through accept and respond as nothing is
// fetched. Items are handled one at a time, and a result that is not yet taken holds the
// block in its last step until rsp_tready frees the output register.
`include "assert_macros.svh"

module lc2k_instruction_executor
   import lc2k_pkg::*;
#(
   parameter int MEM_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // address[15:0], reg_index[18:16], data[50:19], zero pad
   input  logic [1:0]  req_tuser,  // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // next_pc[31:0], read_data[63:32], executed_count[95:64]
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   localparam int MemAddrW = $clog2(MEM_DEPTH);

   // request payload fields
   logic [ADDR_W-1:0]    req_address;
   logic [REG_IDX_W-1:0] req_reg_index;
   logic [DATA_W-1:0]    req_data;
   oper_type             req_oper;

   assign req_address   = req_tdata[15:0];
   assign req_reg_index = req_tdata[18:16];
   assign req_data      = req_tdata[50:19];
   assign req_oper      = oper_type'(req_tuser);

   // control state
   state_type             state_ff, state_in;
   logic [MemAddrW-1:0]   clr_ff, clr_in;
   logic [DATA_W-1:0]     pc_ff, pc_in;
   logic [DATA_W-1:0]     count_ff, count_in;
   logic                  halted_ff, halted_in;

   // captured item
   oper_type              oper_ff, oper_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  addr_ok_ff, addr_ok_in;
   logic [DATA_W-1:0]     data_ff, data_in;
   logic [DATA_W-1:0]     instr_ff, instr_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]     rsp_pc_ff, rsp_pc_in;
   logic [DATA_W-1:0]     rsp_rdata_ff, rsp_rdata_in;
   logic [DATA_W-1:0]     rsp_count_ff, rsp_count_in;

   // memory ports
   word_req_type          word_req;
   logic [DATA_W-1:0]     word_rdata;
   rf_req_type            rf_req;
   logic [DATA_W-1:0]     rf_rdata_a;
   logic [DATA_W-1:0]     rf_rdata_b;

   lc2k_word_mem #(
      .Depth (MEM_DEPTH)
   ) u_word_mem (
      .clock (clock),
      .req   (word_req),
      .rdata (word_rdata)
   );

   lc2k_reg_file u_reg_file (
      .clock   (clock),
      .req     (rf_req),
      .rdata_a (rf_rdata_a),
      .rdata_b (rf_rdata_b)
   );

   // range checks
   logic req_addr_ok;
   logic pc_ok;
   logic out_free;

   assign req_addr_ok = ({1'b0, req_address} < (ADDR_W + 1)'(MEM_DEPTH));
   assign pc_ok       = !pc_ff[DATA_W-1] && (pc_ff < DATA_W'(MEM_DEPTH));
   // output register is free now or is emptied at this edge
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // decode of the held instruction
   opcode_type           opcode;
   logic [REG_IDX_W-1:0] ra_idx;
   logic [REG_IDX_W-1:0] rb_idx;
   logic [REG_IDX_W-1:0] rd_idx;
   logic [DATA_W-1:0]    offset_ext;
   logic [DATA_W:0]      data_addr;
   logic                 data_ok;
   logic [DATA_W-1:0]    pc_next;
   logic [DATA_W-1:0]    sum_val;
   logic [DATA_W-1:0]    nor_val;

   assign opcode     = opcode_type'(instr_ff[OPC_LSB +: 3]);
   assign ra_idx     = instr_ff[RA_LSB +: REG_IDX_W];
   assign rb_idx     = instr_ff[RB_LSB +: REG_IDX_W];
   assign rd_idx     = instr_ff[RD_LSB +: REG_IDX_W];
   assign offset_ext = {{(DATA_W - OFF_W){instr_ff[OFF_W-1]}}, instr_ff[OFF_W-1:0]};
   // signed address without wrap, one bit wider than a word
   assign data_addr  = {rf_rdata_a[DATA_W-1], rf_rdata_a} +
                       {offset_ext[DATA_W-1], offset_ext};
   assign data_ok    = !data_addr[DATA_W] && (data_addr[DATA_W-1:0] < DATA_W'(MEM_DEPTH));
   assign pc_next    = pc_ff + DATA_W'(1);
   assign sum_val    = rf_rdata_a + rf_rdata_b;
   assign nor_val    = ~(rf_rdata_a | rf_rdata_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oper_ff       <= oper_in;
      addr_ff       <= addr_in;
      addr_ok_ff    <= addr_ok_in;
      data_ff       <= data_in;
      instr_ff      <= instr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      logic load_rsp;

      load_rsp      = 1'b0;
      state_in      = state_ff;
      clr_in        = clr_ff;
      pc_in         = pc_ff;
      count_in      = count_ff;
      halted_in     = halted_ff;
      oper_in       = oper_ff;
      addr_in       = addr_ff;
      addr_ok_in    = addr_ok_ff;
      data_in       = data_ff;
      instr_in      = instr_ff;
      rsp_status_in = halted_ff ? STAT_HALTED : STAT_OK;
      rsp_pc_in     = pc_ff;
      rsp_rdata_in  = '0;
      rsp_count_in  = count_ff;
      word_req      = '0;
      rf_req        = '0;
      req_tready    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // zero sweep; the register file rides along on the low address bits
            word_req.wr_en = 1'b1;
            word_req.addr  = ADDR_W'(clr_ff);
            rf_req.wr_en   = 1'b1;
            rf_req.wr_idx  = clr_ff[REG_IDX_W-1:0];
            clr_in         = clr_ff + MemAddrW'(1);
            if (clr_ff == MemAddrW'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               oper_in    = req_oper;
               addr_in    = req_address;
               addr_ok_in = req_addr_ok;
               data_in    = req_data;
               state_in   = ST_RESP;
               case (req_oper)
                  OPER_RDREG: begin
                     rf_req.rd_en    = 1'b1;
                     rf_req.rd_idx_a = req_reg_index;
                  end
                  OPER_RDMEM: begin
                     word_req.rd_en = req_addr_ok;
                     word_req.addr  = req_address;
                  end
                  OPER_EXEC: begin
                     // instruction fetch starts with the transfer
                     if (!halted_ff && pc_ok) begin
                        word_req.rd_en = 1'b1;
                        word_req.addr  = pc_ff[ADDR_W-1:0];
                        state_in       = ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RESP: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
               case (oper_ff)
                  OPER_LOAD: begin
                     if (addr_ok_ff) begin
                        word_req.wr_en = 1'b1;
                        word_req.addr  = addr_ff;
                        word_req.wdata = data_ff;
                     end else begin
                        rsp_status_in = STAT_ADDR_RANGE;
                     end
                  end
                  OPER_RDREG: begin
                     rsp_rdata_in = rf_rdata_a;
                  end
                  OPER_RDMEM: begin
                     if (addr_ok_ff) begin
                        rsp_rdata_in = word_rdata;
                     end else begin
                        rsp_status_in = STAT_ADDR_RANGE;
                     end
                  end
                  default: begin
                     // execute that never fetched: halted already, or pc out of range
                     if (!halted_ff) begin
                        halted_in     = 1'b1;
                        rsp_status_in = STAT_PC_RANGE;
                     end
                  end
               endcase
            end
         end
         ST_FETCH: begin
            instr_in        = word_rdata;
            rf_req.rd_en    = 1'b1;
            rf_req.rd_idx_a = word_rdata[RA_LSB +: REG_IDX_W];
            rf_req.rd_idx_b = word_rdata[RB_LSB +: REG_IDX_W];
            state_in        = ST_EXEC;
         end
         ST_EXEC: begin
            if (opcode == OPC_LW && data_ok) begin
               // data read takes the word port once more
               word_req.rd_en = 1'b1;
               word_req.addr  = data_addr[ADDR_W-1:0];
               state_in       = ST_LOAD;
            end else if (out_free) begin
               load_rsp      = 1'b1;
               state_in      = ST_IDLE;
               count_in      = count_ff + DATA_W'(1);
               pc_in         = pc_next;
               rsp_status_in = STAT_OK;
               case (opcode)
                  OPC_ADD: begin
                     rf_req.wr_en   = 1'b1;
                     rf_req.wr_idx  = rd_idx;
                     rf_req.wr_data = sum_val;
                  end
                  OPC_NOR: begin
                     rf_req.wr_en   = 1'b1;
                     rf_req.wr_idx  = rd_idx;
                     rf_req.wr_data = nor_val;
                  end
                  OPC_LW, OPC_SW: begin
                     if (data_ok) begin
                        word_req.wr_en = 1'b1;
                        word_req.addr  = data_addr[ADDR_W-1:0];
                        word_req.wdata = rf_rdata_b;
                     end else begin
                        halted_in     = 1'b1;
                        rsp_status_in = STAT_ADDR_RANGE;
                     end
                  end
                  OPC_BEQ: begin
                     if (rf_rdata_a == rf_rdata_b) begin
                        pc_in = pc_next + offset_ext;
                     end
                  end
                  OPC_JALR: begin
                     // link first; regA then reads the link when both name the same register
                     rf_req.wr_en   = 1'b1;
                     rf_req.wr_idx  = rb_idx;
                     rf_req.wr_data = pc_next;
                     pc_in          = (ra_idx == rb_idx) ? pc_next : rf_rdata_a;
                  end
                  OPC_HALT: begin
                     halted_in     = 1'b1;
                     rsp_status_in = STAT_HALTED;
                  end
                  default: begin
                  end
               endcase
               rsp_pc_in    = pc_in;
               rsp_count_in = count_in;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               load_rsp       = 1'b1;
               state_in       = ST_IDLE;
               rf_req.wr_en   = 1'b1;
               rf_req.wr_idx  = rb_idx;
               rf_req.wr_data = word_rdata;
               count_in       = count_ff + DATA_W'(1);
               pc_in          = pc_next;
               rsp_status_in  = STAT_OK;
               rsp_pc_in      = pc_next;
               rsp_count_in   = count_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output register: taken transfer empties it, a finished item fills it
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (!load_rsp) begin
         rsp_status_in = rsp_status_ff;
         rsp_pc_in     = rsp_pc_ff;
         rsp_rdata_in  = rsp_rdata_ff;
         rsp_count_in  = rsp_count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_rdata_ff, rsp_pc_ff};
   assign rsp_tuser  = rsp_status_ff;

   // terms for the checks below
   logic in_clear;
   logic in_commit;
   logic word_port_both;

   assign in_clear       = (state_ff == ST_CLEAR);
   assign in_commit      = (state_ff == ST_EXEC) || (state_ff == ST_LOAD);
   assign word_port_both = word_req.wr_en && word_req.rd_en;

   // no request taken while the zero sweep runs
   `ASSERT_NEVER(a_no_req_in_clear, clock, reset, in_clear && req_tready, "request during clear")
   // only reset leaves the halted state
   `ASSERT_CLK(a_halted_sticky, clock, reset, halted_ff |=> halted_ff, "halted mark dropped")
   // the instruction count moves only when an executed instruction commits
   `ASSERT_CLK(a_count_on_commit, clock, reset, !in_commit |=> $stable(count_ff), "count moved")
   // the word memory port does one access per cycle
   `ASSERT_NEVER(a_word_port_single, clock, reset, word_port_both, "word port read and write")

endmodule

// File: test/tb_lc2k_instruction_executor.sv
module tb_lc2k_instruction_executor;
   timeunit 1ns;
   timeprecision 1ps;
   import lc2k_pkg::*;

   localparam int MEM_DEPTH     = 65536;
   localparam int ITEM_TARGET   = 600;     // random transfers after the directed program
   localparam int SETTLE_CYCLES = 10;      // an lw with its result held is the longest item
   localparam int CYCLE_LIMIT   = 400000;  // clearing pass plus every item at its slowest

   // one request transfer, fields as the block sees them
   typedef struct {
      oper_type  oper;
      bit [15:0] address;
      bit [2:0]  reg_index;
      bit [31:0] data;
   } machine_cmd_type;

   // one response transfer
   typedef struct {
      status_type status;
      bit [31:0]  next_pc;
      bit [31:0]  read_data;
      bit [31:0]  executed_count;
   } machine_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // address[15:0], reg_index[18:16], data[50:19], zero pad
   logic [1:0]  req_tuser = '0;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;        // next_pc[31:0], read_data[63:32], executed_count[95:64]
   logic [1:0]  rsp_tuser;        // status[1:0]

   // shadow of the machine, updated as each request transfer is accepted
   bit [31:0] mem_image [MEM_DEPTH];
   bit [31:0] reg_image [REG_COUNT];
   bit [31:0] pc_image;
   bit        halted_image;
   bit [31:0] retired_count;

   machine_cmd_type    pending_cmds[$];
   machine_result_type expected_results[$];
   machine_cmd_type    inflight_cmd;

   int send_idle_pct = 33;
   int recv_idle_pct = 67;
   int sent_count    = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   lc2k_instruction_executor #(
      .MEM_DEPTH(MEM_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #2 clock = ~clock;

   // fetch, decode and retire one instruction at the shadow pc
   function automatic status_type step_machine();
      int         pc_signed;
      int         base;
      shortint    off;
      longint     addr;
      bit [31:0]  word;
      bit [31:0]  next;
      opcode_type opc;
      bit [2:0]   ra;
      bit [2:0]   rb;
      bit [2:0]   rd;
      pc_signed = pc_image;
      // a pc outside memory halts before anything is fetched or counted
      if (pc_signed < 0 || pc_signed >= MEM_DEPTH) begin
         halted_image = 1'b1;
         return STAT_PC_RANGE;
      end
      word = mem_image[pc_signed];
      opc  = opcode_type'(word[OPC_LSB +: 3]);
      ra   = word[RA_LSB +: 3];
      rb   = word[RB_LSB +: 3];
      rd   = word[RD_LSB +: 3];
      off  = word[15:0];
      next = pc_image + 1;
      retired_count++;
      pc_image = next;
      case (opc)
         OPC_ADD: reg_image[rd] = reg_image[ra] + reg_image[rb];
         OPC_NOR: reg_image[rd] = ~(reg_image[ra] | reg_image[rb]);
         OPC_LW, OPC_SW: begin
            // effective address formed without wrap, still counted when out of range
            base = reg_image[ra];
            addr = longint'(base) + longint'(off);
            if (addr < 0 || addr >= MEM_DEPTH) begin
               halted_image = 1'b1;
               return STAT_ADDR_RANGE;
            end
            if (opc == OPC_LW) reg_image[rb] = mem_image[addr];
            else mem_image[addr] = reg_image[rb];
         end
         OPC_BEQ: if (reg_image[ra] == reg_image[rb]) pc_image = next + int'(off);
         OPC_JALR: begin
            // link first, so regA equal to regB jumps to the link value
            reg_image[rb] = next;
            pc_image = reg_image[ra];
         end
         OPC_HALT: begin
            halted_image = 1'b1;
            return STAT_HALTED;
         end
         default: ;
      endcase
      return STAT_OK;
   endfunction

   // result of one request transfer, applied to the shadow state
   function automatic machine_result_type predict_result(machine_cmd_type cmd);
      machine_result_type res;
      res.status    = halted_image ? STAT_HALTED : STAT_OK;
      res.read_data = '0;
      case (cmd.oper)
         OPER_LOAD: begin
            if (cmd.address < MEM_DEPTH) mem_image[cmd.address] = cmd.data;
            else res.status = STAT_ADDR_RANGE;
         end
         OPER_EXEC: if (!halted_image) res.status = step_machine();
         OPER_RDREG: res.read_data = reg_image[cmd.reg_index];
         default: begin
            if (cmd.address < MEM_DEPTH) res.read_data = mem_image[cmd.address];
            else res.status = STAT_ADDR_RANGE;
         end
      endcase
      res.next_pc        = pc_image;
      res.executed_count = retired_count;
      return res;
   endfunction

   // instruction word; fields no opcode uses carry random bits
   function automatic bit [31:0] encode_instr(opcode_type opc, int ra, int rb, int low);
      bit [31:0] word;
      word = $urandom;
      word[OPC_LSB +: 3] = opc;
      word[RA_LSB +: 3]  = ra[2:0];
      word[RB_LSB +: 3]  = rb[2:0];
      if (opc inside {OPC_ADD, OPC_NOR}) word[2:0] = low[2:0];
      else if (opc inside {OPC_LW, OPC_SW, OPC_BEQ}) word[15:0] = low[15:0];
      return word;
   endfunction

   // random 16-bit offset that keeps base + offset inside memory
   function automatic bit fit_offset(longint base, output int off);
      longint lo;
      longint hi;
      lo  = (-base > -32768) ? -base : -32768;
      hi  = (MEM_DEPTH - 1 - base < 32767) ? MEM_DEPTH - 1 - base : 32767;
      off = 0;
      if (lo > hi) return 1'b0;
      off = int'(lo) + int'($urandom_range(0, int'(hi - lo)));
      return 1'b1;
   endfunction

   // half the accesses land in the low words where data tends to live
   function automatic int pick_address();
      return $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
   endfunction

   function automatic void push_cmd(oper_type oper, int address, int reg_index,
                                    bit [31:0] data);
      machine_cmd_type cmd;
      cmd.oper      = oper;
      cmd.address   = address[15:0];
      cmd.reg_index = reg_index[2:0];
      cmd.data      = data;
      pending_cmds.push_back(cmd);
      sent_count++;
   endfunction

   // place a word at the current pc and execute it
   function automatic void run_word(bit [31:0] word);
      push_cmd(OPER_LOAD, pc_image[15:0], $urandom_range(0, 7), word);
      push_cmd(OPER_EXEC, $urandom, $urandom_range(0, 7), $urandom);
   endfunction

   // every queued transfer has been accepted, so the shadow state is current
   task automatic wait_accepted();
      do @(negedge clock); while (pending_cmds.size() != 0 || req_tvalid);
   endtask

   task automatic drain();
      wait_accepted();
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // one random instruction that cannot halt the machine
   task automatic program_step();
      int         roll;
      int         ra;
      int         rb;
      int         off;
      int         tries;
      int         v;
      bit         ok;
      opcode_type opc;
      bit [31:0]  word;
      wait_accepted();
      roll = $urandom_range(0, 99);
      ra   = $urandom_range(0, 7);
      rb   = $urandom_range(0, 7);
      if (roll < 20) opc = OPC_ADD;
      else if (roll < 32) opc = OPC_NOR;
      else if (roll < 52) opc = OPC_LW;
      else if (roll < 67) opc = OPC_SW;
      else if (roll < 82) opc = OPC_BEQ;
      else if (roll < 92) opc = OPC_JALR;
      else opc = OPC_NOOP;
      word = encode_instr(opc, ra, rb, $urandom_range(0, 7));
      ok   = 1'b0;
      case (opc)
         OPC_LW, OPC_SW: begin
            // look for a base register from which some offset stays in memory
            for (tries = 0; tries < 8 && !ok; tries++) begin
               ra = $urandom_range(0, 7);
               ok = fit_offset(longint'(int'(reg_image[ra])), off);
            end
            word = ok ? encode_instr(opc, ra, rb, off) : encode_instr(OPC_NOR, ra, rb, rb);
         end
         OPC_BEQ: begin
            // equal operands force the branch half the time
            if ($urandom_range(0, 1)) rb = ra;
            void'(fit_offset(longint'(pc_image) + 1, off));
            word = encode_instr(opc, ra, rb, off);
         end
         OPC_JALR: begin
            for (tries = 0; tries < 8 && !ok; tries++) begin
               ra = $urandom_range(0, 7);
               v  = reg_image[ra];
               ok = v >= 0 && v < MEM_DEPTH;
            end
            word = encode_instr(ok ? OPC_JALR : OPC_NOOP, ra, rb, 0);
         end
         default: ;
      endcase
      run_word(word);
   endtask

   // end the program: halt, pc leaving memory, or data access outside memory
   task automatic stop_machine();
      int        kind;
      int        ra;
      int        off;
      int        tries;
      int        v;
      longint    addr;
      bit        ok;
      bit [31:0] word;
      wait_accepted();
      kind = $urandom_range(0, 2);
      word = encode_instr(OPC_HALT, $urandom_range(0, 7), $urandom_range(0, 7), 0);
      if (kind == 1) begin
         // no branch offset leaves memory from this pc, so step past it
         if (pc_image == 32767) begin
            run_word(encode_instr(OPC_NOOP, 0, 0, 0));
            wait_accepted();
         end
         ra = $urandom_range(0, 7);
         v  = reg_image[ra];
         if (v < 0 || v >= MEM_DEPTH) begin
            // link into another register so the wild target survives
            word = encode_instr(OPC_JALR, ra, (ra + $urandom_range(1, 7)) % 8, 0);
         end else begin
            word = encode_instr(OPC_BEQ, ra, ra, (pc_image < 32767) ? -32768 : 32767);
         end
         run_word(word);
         push_cmd(OPER_EXEC, $urandom, $urandom_range(0, 7), $urandom);
      end else begin
         if (kind == 2) begin
            ok = 1'b0;
            for (tries = 0; tries < 200 && !ok; tries++) begin
               ra   = $urandom_range(0, 7);
               off  = int'(shortint'($urandom));
               addr = longint'(int'(reg_image[ra])) + off;
               ok   = addr < 0 || addr >= MEM_DEPTH;
            end
            if (ok) begin
               word = encode_instr($urandom_range(0, 1) ? OPC_LW : OPC_SW, ra,
                                   $urandom_range(0, 7), off);
            end
         end
         run_word(word);
      end
   endtask

   // request side: feeds pending transfers, predicts each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_results.push_back(predict_result(inflight_cmd));
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               inflight_cmd = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= inflight_cmd.oper;
               req_tdata  <= {5'b0, inflight_cmd.data, inflight_cmd.reg_index,
                              inflight_cmd.address};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
         error_count++;
      end
   endfunction

   // response side: random backpressure, each transfer against the oldest expectation
   always @(posedge clock) begin
      machine_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("response transfer with no request outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_tuser);
               check_field("next_pc", want.next_pc, rsp_tdata[31:0]);
               check_field("read_data", want.read_data, rsp_tdata[63:32]);
               check_field("executed_count", want.executed_count, rsp_tdata[95:64]);
            end
         end
         rsp_tready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   // watchdog, sized for the clearing pass after reset plus a slow run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_lc2k_instruction_executor failed");
         $finish;
      end
   end

   initial begin
      int phase;
      int roll;
      int random_start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed program: every opcode but halt, wrapping add, taken and fallen-through
      // branches, sw storing regB, jalr with regA equal to regB
      push_cmd(OPER_LOAD, 100, 0, 32'h7fff_ffff);
      push_cmd(OPER_LOAD, 0, 0, encode_instr(OPC_LW, 0, 1, 100));
      push_cmd(OPER_LOAD, 1, 0, encode_instr(OPC_ADD, 1, 1, 3));
      push_cmd(OPER_LOAD, 2, 0, encode_instr(OPC_NOR, 1, 0, 4));
      push_cmd(OPER_LOAD, 3, 0, encode_instr(OPC_SW, 0, 4, 101));
      push_cmd(OPER_LOAD, 4, 0, encode_instr(OPC_BEQ, 0, 0, 1));
      push_cmd(OPER_LOAD, 5, 0, encode_instr(OPC_HALT, 0, 0, 0));   // branched over
      push_cmd(OPER_LOAD, 6, 0, encode_instr(OPC_BEQ, 1, 4, -6));
      push_cmd(OPER_LOAD, 7, 0, encode_instr(OPC_JALR, 5, 5, 0));
      push_cmd(OPER_LOAD, 8, 0, encode_instr(OPC_NOOP, 0, 0, 0));
      repeat (8) push_cmd(OPER_EXEC, 0, 0, 0);
      push_cmd(OPER_RDREG, 0, 3, 0);
      push_cmd(OPER_RDREG, 0, 4, 0);
      push_cmd(OPER_RDREG, 0, 5, 0);
      push_cmd(OPER_RDMEM, 101, 0, 0);
      push_cmd(OPER_LOAD, 16'hffff, 7, 32'h8000_0000);
      push_cmd(OPER_RDMEM, 16'hffff, 7, 32'hffff_ffff);

      // hold the sender until everything so far has come back
      drain();

      // random program with loads and reads mixed in; idling profile per third
      phase        = 0;
      random_start = sent_count;
      while (sent_count - random_start < ITEM_TARGET) begin
         if (phase != (sent_count - random_start) * 3 / ITEM_TARGET) begin
            drain();
            phase++;
            if (phase == 1) begin
               send_idle_pct = 67;
               recv_idle_pct = 33;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         end
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            program_step();
         end else if (roll < 74) begin
            push_cmd(OPER_LOAD, pick_address(), $urandom_range(0, 7),
                     $urandom_range(0, 1) ? $urandom : $urandom_range(0, 70000));
         end else if (roll < 87) begin
            push_cmd(OPER_RDREG, $urandom, $urandom_range(0, 7), $urandom);
         end else begin
            push_cmd(OPER_RDMEM, pick_address(), $urandom_range(0, 7), $urandom);
         end
      end

      // the halted mark is sticky, so the stopping case comes last
      stop_machine();
      repeat (16) begin
         push_cmd(oper_type'($urandom_range(0, 3)), pick_address(), $urandom_range(0, 7),
                  $urandom);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_lc2k_instruction_executor passed");
      end else begin
         $display("tb_lc2k_instruction_executor failed");
      end
      $finish;
   end

endmodule
